// ----- design/assert_macros.svh -----
// assertion macros shared by the design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/kvi_pkg.sv -----
`default_nettype none
package kvi_pkg;
    localparam int NUM_KEYS = 64;
    localparam int IDX_W = $clog2(NUM_KEYS);
    localparam int CNT_W = 7;
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] FRAC_ONE = 17'h10000;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_CLAMP = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // transaction passed from front to back
    typedef struct packed {
        logic        cmd;
        logic [5:0]  key_index;
        logic [31:0] key_time;
        logic [31:0] key_x;
        logic [31:0] key_y;
        logic [31:0] key_z;
        logic [31:0] sample_time;
    } item_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [1:0]  status;
    } result_t;
endpackage
`default_nettype wire

// ----- design/kvi_fifo.sv -----
`default_nettype none
// two-entry queue between front and back
module kvi_fifo (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  kvi_pkg::item_t    push_data,
    output logic              full,
    input  wire               pop,
    output kvi_pkg::item_t    pop_data,
    output logic              empty
);
    kvi_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
        end
    end
endmodule
`default_nettype wire

// ----- design/kvi_back.sv -----
`default_nettype none
// key table, segment search, serial divide and lerp
module kvi_back (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire [kvi_pkg::CNT_W-1:0]   key_count,
    input  wire                        in_valid,
    input  kvi_pkg::item_t             in_item,
    output logic                       in_take,
    output logic                       res_valid,
    output kvi_pkg::result_t           res_data,
    input  wire                        res_pop
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SRCH  = 8'b00000010,
        S_RDSEG = 8'b00000100,
        S_PREP  = 8'b00001000,
        S_DIV   = 8'b00010000,
        S_MUL   = 8'b00100000,
        S_ADD   = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    localparam int IW = kvi_pkg::IDX_W;

    logic [31:0] t_mem [kvi_pkg::NUM_KEYS];
    logic [31:0] x_mem [kvi_pkg::NUM_KEYS];
    logic [31:0] y_mem [kvi_pkg::NUM_KEYS];
    logic [31:0] z_mem [kvi_pkg::NUM_KEYS];

    state_t state_reg, state_next;
    logic [IW:0]  idx_reg;
    logic [IW:0]  cnt_reg;
    logic [31:0]  st_reg;
    logic [IW-1:0] seg_reg;
    logic          found_reg;
    logic [31:0]  rd_t_reg, rd_x_reg, rd_y_reg, rd_z_reg;
    logic          rd_phase_reg;
    logic [31:0]  t0_reg, t1_reg;
    logic [31:0]  a_reg [3];
    logic [31:0]  b_reg [3];
    logic [32:0]  rem_reg;
    logic [31:0]  len_reg;
    logic [47:0]  num_reg;
    logic [16:0]  fac_reg;
    logic [4:0]   step_reg;
    logic [5:0]   bit_reg;
    logic [1:0]   comp_reg;
    logic signed [50:0] prod_reg;
    logic [31:0]  res_reg [3];
    logic [1:0]   status_reg;
    logic          valid_reg;
    kvi_pkg::result_t out_reg;

    logic [IW:0]  cnt_clip;
    logic [IW-1:0] rd_addr;
    logic [32:0]  sub_try;
    logic signed [32:0] diff;
    logic signed [50:0] prod_w;
    logic signed [34:0] q_w;

    assign cnt_clip = (key_count > kvi_pkg::CNT_W'(kvi_pkg::NUM_KEYS))
                      ? (IW+1)'(kvi_pkg::NUM_KEYS) : key_count[IW:0];

    // read address: searching or segment fetch
    always_comb
    begin
        if (state_reg == S_RDSEG)
        begin
            rd_addr = rd_phase_reg ? IW'(seg_reg + 1'b1) : seg_reg;
        end
        else
        begin
            rd_addr = idx_reg[IW-1:0];
        end
    end

    // key table
    always_ff @(posedge clk)
    begin
        if (in_take && in_item.cmd == kvi_pkg::CMD_WRITE)
        begin
            t_mem[in_item.key_index[IW-1:0]] <= in_item.key_time;
            x_mem[in_item.key_index[IW-1:0]] <= in_item.key_x;
            y_mem[in_item.key_index[IW-1:0]] <= in_item.key_y;
            z_mem[in_item.key_index[IW-1:0]] <= in_item.key_z;
        end
        rd_t_reg <= t_mem[rd_addr];
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
        rd_z_reg <= z_mem[rd_addr];
    end

    assign in_take = (state_reg == S_IDLE) && in_valid;
    assign res_valid = valid_reg;
    assign res_data = out_reg;

    assign sub_try = {rem_reg[31:0], num_reg[47]} - {1'b0, len_reg};
    assign diff = $signed({b_reg[comp_reg][31], b_reg[comp_reg]})
                - $signed({a_reg[comp_reg][31], a_reg[comp_reg]});
    assign prod_w = $signed({1'b0, fac_reg}) * diff;
    assign q_w = 35'(prod_reg >>> kvi_pkg::FRAC_BITS);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_take && in_item.cmd == kvi_pkg::CMD_SAMPLE) state_next = S_SRCH;
            S_SRCH:  ;
            S_RDSEG: ;
            S_PREP:  ;
            S_DIV:   ;
            S_MUL:   ;
            S_ADD:   ;
            S_DONE:  if (!valid_reg || res_pop) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            out_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            rd_phase_reg <= 1'b0;
            step_reg <= '0;
            comp_reg <= '0;
            bit_reg <= '0;
            found_reg <= 1'b0;
            seg_reg <= '0;
            status_reg <= kvi_pkg::ST_OK;
        end
        else
        begin
            // output register: load a finished result once the slot is free
            if (state_reg == S_DONE && (!valid_reg || res_pop))
            begin
                valid_reg <= 1'b1;
                out_reg <= '{x: res_reg[0], y: res_reg[1], z: res_reg[2],
                             status: status_reg};
            end
            else if (valid_reg && res_pop)
            begin
                valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_take && in_item.cmd == kvi_pkg::CMD_SAMPLE)
                    begin
                        st_reg <= in_item.sample_time;
                        cnt_reg <= cnt_clip;
                        step_reg <= '0;
                        found_reg <= 1'b0;
                        seg_reg <= '0;
                        if (cnt_clip == '0)
                        begin
                            res_reg[0] <= '0;
                            res_reg[1] <= '0;
                            res_reg[2] <= '0;
                            status_reg <= kvi_pkg::ST_EMPTY;
                            state_reg <= S_DONE;
                        end
                        else if (cnt_clip == (IW+1)'(1))
                        begin
                            idx_reg <= '0;
                            status_reg <= kvi_pkg::ST_OK;
                            state_reg <= S_SRCH;
                        end
                        else
                        begin
                            idx_reg <= (IW+1)'(1);
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_SRCH:
                begin
                    // step 0 issues read, step 1 checks data
                    if (step_reg == 5'd0)
                    begin
                        step_reg <= 5'd1;
                    end
                    else if (cnt_reg == (IW+1)'(1))
                    begin
                        res_reg[0] <= rd_x_reg;
                        res_reg[1] <= rd_y_reg;
                        res_reg[2] <= rd_z_reg;
                        state_reg <= S_DONE;
                    end
                    else if (st_reg < rd_t_reg)
                    begin
                        seg_reg <= IW'(idx_reg - 1'b1);
                        found_reg <= 1'b1;
                        rd_phase_reg <= 1'b0;
                        step_reg <= '0;
                        state_reg <= S_RDSEG;
                    end
                    else if (idx_reg + 1'b1 >= cnt_reg)
                    begin
                        seg_reg <= '0;
                        rd_phase_reg <= 1'b0;
                        step_reg <= '0;
                        state_reg <= S_RDSEG;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        step_reg <= 5'd0;
                    end
                end
                S_RDSEG:
                begin
                    // address seg then seg+1, data arrives through the read register in the next step
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd0)
                    begin
                        rd_phase_reg <= 1'b1;
                    end
                    else if (step_reg == 5'd1)
                    begin
                        t0_reg <= rd_t_reg;
                        a_reg[0] <= rd_x_reg;
                        a_reg[1] <= rd_y_reg;
                        a_reg[2] <= rd_z_reg;
                    end
                    else
                    begin
                        t1_reg <= rd_t_reg;
                        b_reg[0] <= rd_x_reg;
                        b_reg[1] <= rd_y_reg;
                        b_reg[2] <= rd_z_reg;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    // special factor cases, else start the divide
                    status_reg <= found_reg ? kvi_pkg::ST_OK : kvi_pkg::ST_CLAMP;
                    comp_reg <= '0;
                    if (t1_reg <= t0_reg)
                    begin
                        fac_reg <= (st_reg >= t0_reg) ? kvi_pkg::FRAC_ONE : '0;
                        state_reg <= S_MUL;
                    end
                    else if (st_reg <= t0_reg)
                    begin
                        fac_reg <= '0;
                        state_reg <= S_MUL;
                    end
                    else if (st_reg - t0_reg >= t1_reg - t0_reg)
                    begin
                        fac_reg <= kvi_pkg::FRAC_ONE;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        num_reg <= {st_reg - t0_reg, 16'd0};
                        len_reg <= t1_reg - t0_reg;
                        rem_reg <= '0;
                        fac_reg <= '0;
                        bit_reg <= 6'd48;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // restoring divide, one quotient bit a cycle
                    num_reg <= {num_reg[46:0], 1'b0};
                    if (!sub_try[32])
                    begin
                        rem_reg <= {1'b0, sub_try[31:0]};
                        fac_reg <= {fac_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[31:0], num_reg[47]};
                        fac_reg <= {fac_reg[15:0], 1'b0};
                    end
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == 6'd1)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= prod_w;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    // arithmetic shift rounds the scaled delta toward minus infinity
                    res_reg[comp_reg] <= 32'($signed({a_reg[comp_reg][31], a_reg[comp_reg]})
                                       + 33'(q_w));
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        comp_reg <= comp_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE:
                begin
                    state_reg <= state_next;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/keyframe_vector_interpolator.sv -----
`default_nettype none
`include "assert_macros.svh"
// Keyframe track sampler: a key write (cmd 0) stores time and x/y/z at key_index and
// yields nothing; a sample (cmd 1) yields one interpolated vector and a status. Items
// enter a two-deep queue and are processed one at a time by a sequencer around a
// key table with one write port and one read port. A write is stored as it is taken.
// A sample is accepted, compares keys in turn (at most key_count - 1), fetches the
// segment, sets up the factor, runs the bit-serial divide (skipped when the factor is
// 0 or 1.0), does the three multiply-adds and loads the result; a single-key track
// returns key 0 and an empty track returns zeros. The output register lets the next
// item start as soon as the result is loaded; a finished sample waits only while an
// older result is still not popped. Write key_count only while idle; samples may only
// touch keys that were written.
module keyframe_vector_interpolator (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [6:0]  cfg_wdata,
    input  wire         push,
    output logic        full,
    input  wire         cmd,
    input  wire  [5:0]  key_index,
    input  wire  [31:0] key_time,
    input  wire  [31:0] key_x,
    input  wire  [31:0] key_y,
    input  wire  [31:0] key_z,
    input  wire  [31:0] sample_time,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [1:0]  status
);
    logic [6:0] key_count_reg;
    kvi_pkg::item_t push_item;
    kvi_pkg::item_t q_item;
    kvi_pkg::result_t res;
    logic q_empty;
    logic take;
    logic res_valid;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            key_count_reg <= cfg_wdata;
        end
    end

    // incoming transaction
    assign push_item = '{cmd: cmd, key_index: key_index, key_time: key_time, key_x: key_x,
                         key_y: key_y, key_z: key_z, sample_time: sample_time};

    kvi_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .full      (full),
        .pop       (take),
        .pop_data  (q_item),
        .empty     (q_empty)
    );

    kvi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_count (key_count_reg),
        .in_valid  (!q_empty),
        .in_item   (q_item),
        .in_take   (take),
        .res_valid (res_valid),
        .res_data  (res),
        .res_pop   (pop)
    );

    assign empty = !res_valid;
    assign out_x = res.x;
    assign out_y = res.y;
    assign out_z = res.z;
    assign status = res.status;

    `ASSERT_IMPL(a_status_range, clk, rst_n, !empty, status != 2'd3, "bad status code")
    `ASSERT_NEXT(a_res_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_x),
                 "result dropped while waiting")
    `ASSERT_IMPL(a_empty_zero, clk, rst_n, !empty && status == kvi_pkg::ST_EMPTY,
                 out_x == 32'd0, "empty track result not zero")
endmodule
`default_nettype wire

// ----- verif/keyframe_vector_interpolator_test.sv -----
`timescale 1ns / 1ps
module keyframe_vector_interpolator_test;
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        push;
    logic        full;
    logic        cmd;
    logic [5:0]  key_index;
    logic [31:0] key_time;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
    logic [31:0] sample_time;
    logic        empty;
    logic        pop;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [1:0]  status;

    keyframe_vector_interpolator uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .push(push), .full(full), .cmd(cmd), .key_index(key_index),
        .key_time(key_time), .key_x(key_x), .key_y(key_y), .key_z(key_z),
        .sample_time(sample_time), .empty(empty), .pop(pop),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status)
    );

    // shadow of the track held by the block
    logic [31:0] trk_time [kvi_pkg::NUM_KEYS];
    logic [31:0] trk_x [kvi_pkg::NUM_KEYS];
    logic [31:0] trk_y [kvi_pkg::NUM_KEYS];
    logic [31:0] trk_z [kvi_pkg::NUM_KEYS];
    int unsigned trk_count;

    kvi_pkg::item_t   pending_items[$];
    kvi_pkg::result_t expected_samples[$];
    kvi_pkg::item_t   cur;

    int  errors = 0;
    int  n_writes = 0;
    int  n_samples = 0;
    int  n_checked = 0;
    int  n_clamped = 0;
    int  n_empty_track = 0;
    bit  tx_steady = 1;
    bit  rx_steady = 1;
    bit  rx_hold = 0;
    int  burst_left = 0;
    int  gap_left = 0;

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // append one transaction to the driver's queue
    function automatic void queue_item(kvi_pkg::item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // one lerp component, rounding the product toward minus infinity
    function automatic logic [31:0] lerp_axis(logic [31:0] a, logic [31:0] b,
                                              longint factor);
        longint s;
        longint d;
        longint p;
        longint q;
        s = longint'(signed'(a));
        d = longint'(signed'(b)) - s;
        p = factor * d;
        if (p >= 0)
            q = p / 65536;
        else
            q = -((-p + 65535) / 65536);
        return 32'(s + q);
    endfunction

    // expected output of a sample at time t
    function automatic kvi_pkg::result_t sample_track(logic [31:0] t);
        kvi_pkg::result_t r;
        int unsigned cnt;
        int seg;
        bit found;
        longint offset;
        longint seg_len;
        longint factor;
        cnt = (trk_count > kvi_pkg::NUM_KEYS) ? kvi_pkg::NUM_KEYS : trk_count;
        seg = 0;
        found = 0;
        if (cnt == 0)
        begin
            r = '{x: 32'd0, y: 32'd0, z: 32'd0, status: kvi_pkg::ST_EMPTY};
            return r;
        end
        if (cnt == 1)
        begin
            r = '{x: trk_x[0], y: trk_y[0], z: trk_z[0], status: kvi_pkg::ST_OK};
            return r;
        end
        for (int i = 0; i + 1 < cnt; i++)
        begin
            if (t < trk_time[i + 1])
            begin
                seg = i;
                found = 1;
                break;
            end
        end
        offset = longint'(t) - longint'(trk_time[seg]);
        seg_len = longint'(trk_time[seg + 1]) - longint'(trk_time[seg]);
        if (seg_len <= 0)
            factor = (offset >= 0) ? 65536 : 0;
        else if (offset <= 0)
            factor = 0;
        else if (offset >= seg_len)
            factor = 65536;
        else
            factor = (offset << 16) / seg_len;
        r.x = lerp_axis(trk_x[seg], trk_x[seg + 1], factor);
        r.y = lerp_axis(trk_y[seg], trk_y[seg + 1], factor);
        r.z = lerp_axis(trk_z[seg], trk_z[seg + 1], factor);
        r.status = found ? kvi_pkg::ST_OK : kvi_pkg::ST_CLAMP;
        return r;
    endfunction

    // driver: offers pending transactions, in bursts with gaps when tx_steady is clear
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                if (cur.cmd == kvi_pkg::CMD_WRITE)
                begin
                    trk_time[cur.key_index] = cur.key_time;
                    trk_x[cur.key_index] = cur.key_x;
                    trk_y[cur.key_index] = cur.key_y;
                    trk_z[cur.key_index] = cur.key_z;
                    n_writes++;
                end
                else
                begin
                    expected_samples.insert(expected_samples.size(),
                                            sample_track(cur.sample_time));
                    n_samples++;
                end
            end
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    cur = pending_items.pop_front();
                    cmd <= cur.cmd;
                    key_index <= cur.key_index;
                    key_time <= cur.key_time;
                    key_x <= cur.key_x;
                    key_y <= cur.key_y;
                    key_z <= cur.key_z;
                    sample_time <= cur.sample_time;
                    push <= 1'b1;
                    if (!tx_steady)
                    begin
                        if (burst_left > 0)
                            burst_left--;
                        else
                        begin
                            burst_left = $urandom_range(0, 8);
                            gap_left = $urandom_range(1, 6);
                        end
                    end
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each popped transaction against the oldest expected sample
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("result with no sample pending");
                    errors++;
                end
                else
                begin
                    kvi_pkg::result_t e;
                    e = expected_samples.pop_front();
                    n_checked++;
                    if (e.status == kvi_pkg::ST_CLAMP)
                        n_clamped++;
                    if (e.status == kvi_pkg::ST_EMPTY)
                        n_empty_track++;
                    if (out_x !== e.x)
                    begin
                        $error("out_x expected %h actual %h", e.x, out_x);
                        errors++;
                    end
                    if (out_y !== e.y)
                    begin
                        $error("out_y expected %h actual %h", e.y, out_y);
                        errors++;
                    end
                    if (out_z !== e.z)
                    begin
                        $error("out_z expected %h actual %h", e.z, out_z);
                        errors++;
                    end
                    if (status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, status);
                        errors++;
                    end
                end
            end
            pop <= !rx_hold && (rx_steady || ($urandom_range(0, 2) != 0));
        end
    end

    function automatic kvi_pkg::item_t key_write(logic [5:0] idx, logic [31:0] t,
                                                 logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z);
        kvi_pkg::item_t it;
        it = '{cmd: kvi_pkg::CMD_WRITE, key_index: idx, key_time: t, key_x: x, key_y: y,
               key_z: z, sample_time: $urandom};
        return it;
    endfunction

    function automatic kvi_pkg::item_t track_sample(logic [31:0] t);
        kvi_pkg::item_t it;
        it = '{cmd: kvi_pkg::CMD_SAMPLE, key_index: 6'($urandom), key_time: $urandom,
               key_x: $urandom, key_y: $urandom, key_z: $urandom, sample_time: t};
        return it;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 2000)) - 1000) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // sample time aimed at key times and segment interiors, with some extremes and random times
    function automatic logic [31:0] pick_time(int cnt, logic [31:0] kt[kvi_pkg::NUM_KEYS]);
        int i;
        logic [31:0] lo;
        logic [31:0] hi;
        i = (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
        lo = kt[i];
        hi = (i + 1 < cnt) ? kt[i + 1] : lo;
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return lo;
            3: return lo - 1;
            4: return $urandom;
            default:
                if (hi > lo)
                    return lo + 32'(longint'($urandom) % (longint'(hi - lo) + 1));
                else
                    return lo + $urandom_range(0, 3);
        endcase
    endfunction

    // waits until nothing is queued, in flight or expected
    task automatic drain();
        while (pending_items.size() != 0 || push || expected_samples.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_key_count(logic [6:0] v);
        drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        trk_count = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] kt[kvi_pkg::NUM_KEYS];
        int cnt;
        int layout;
        longint t;
        int total;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        push = 1'b0;
        pop = 1'b0;
        cmd = kvi_pkg::CMD_WRITE;
        key_index = '0;
        key_time = '0;
        key_x = '0;
        key_y = '0;
        key_z = '0;
        sample_time = '0;
        trk_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty track, single key, equal and unsorted times
        set_key_count(7'd0);
        queue_item(track_sample(32'h0));
        queue_item(track_sample(32'hffffffff));
        queue_item(key_write(6'd0, 32'h10000, 32'h7fffffff, 32'h80000000, 0));
        queue_item(key_write(6'd1, 32'h20000, 32'h80000000, 32'h7fffffff, 32'hffffffff));
        queue_item(key_write(6'd2, 32'h20000, 32'h1, 32'hffff0000, 32'h10000));
        queue_item(key_write(6'd3, 32'h18000, 32'h0, 32'h0, 32'h80000000));
        queue_item(key_write(6'd63, 32'hffffffff, 32'hffffffff, 32'h0, 32'h1));
        set_key_count(7'd1);
        queue_item(track_sample(32'h0));
        queue_item(track_sample(32'hffffffff));
        set_key_count(7'd4);
        queue_item(track_sample(32'h0));
        queue_item(track_sample(32'h10000));
        queue_item(track_sample(32'h18000));
        queue_item(track_sample(32'h1ffff));
        queue_item(track_sample(32'h20000));
        queue_item(track_sample(32'hffffffff));
        set_key_count(7'd2);
        queue_item(track_sample(32'h18000));
        queue_item(track_sample(32'h20000));
        queue_item(track_sample(32'hffff));
        total = 18;

        // random tracks: mostly sorted keys, some with repeats or no order at all
        for (int ph = 0; total < 1150; ph++)
        begin
            if (ph == 0 || ph % 6 == 5)
                cnt = 64;
            else if (ph % 11 == 3)
                cnt = $urandom_range(0, 1);
            else
                cnt = $urandom_range(2, 12);
            layout = $urandom_range(0, 9);
            tx_steady = (ph % 4 == 0);
            rx_steady = (ph % 5 == 1);
            t = (layout < 7) ? $urandom_range(0, 3) << 16 : $urandom;
            for (int i = 0; i < kvi_pkg::NUM_KEYS; i++)
            begin
                if (layout >= 9)
                    kt[i] = $urandom;
                else
                begin
                    kt[i] = 32'(t);
                    if (!(layout == 8 && $urandom_range(0, 2) == 0))
                        t = t + ($urandom >> $urandom_range(1, 31)) + 1;
                    if (t > 64'hffffffff)
                        t = 64'hffffffff;
                end
            end
            set_key_count(7'(cnt));
            for (int i = 0; i < cnt; i++)
                queue_item(key_write(6'(i), kt[i], rand_value(), rand_value(),
                                     rand_value()));
            total += cnt;
            if (ph == 2)
            begin
                // long receiver hold while the sender keeps offering
                fork
                    begin
                        rx_hold = 1;
                        repeat (600) @(posedge clk);
                        rx_hold = 0;
                    end
                join_none
            end
            for (int j = 0; j < 24; j++)
            begin
                // noise writes into slots past the live track
                if ($urandom_range(0, 7) == 0 && cnt < kvi_pkg::NUM_KEYS)
                begin
                    queue_item(key_write(6'($urandom_range(cnt, 63)), $urandom,
                                         $urandom, $urandom, $urandom));
                    total++;
                end
                queue_item(track_sample(pick_time(cnt, kt)));
                total++;
            end
        end

        drain();
        $display("%0d key writes and %0d of %0d samples checked (%0d clamped, %0d empty)",
                 n_writes, n_checked, n_samples, n_clamped, n_empty_track);
        $display("track lengths from 0 to 64 keys, sorted, repeated and unordered times");
        if (errors == 0)
            $display("keyframe_vector_interpolator test passed");
        else
            $display("keyframe_vector_interpolator test failed");
        $finish;
    end

    // overall time limit
    initial
    begin
        #40ms;
        $display("keyframe_vector_interpolator test failed");
        $finish;
    end
endmodule

// ----- keyframe_vector_interpolator.f -----
+incdir+design
design/kvi_pkg.sv
design/kvi_fifo.sv
design/kvi_back.sv
design/keyframe_vector_interpolator.sv
verif/keyframe_vector_interpolator_test.sv
